### src/stt_pkg.sv
`default_nettype none
package stt_pkg;

  localparam int SLOTS = 8;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [15:0] HANDLE_BASE = 16'hEEDF;
  localparam logic [19:0] MIN_TIMEBASE = 20'd10;
  localparam logic [19:0] TIMEBASE_RESET = 20'd1000;
  localparam logic [14:0] MAX_RELOAD = 15'h7FFF;

  // Reload divider: numerator 2*d + t, denominator 2*t.
  localparam int NUM_W = 34;
  localparam int DEN_W = 21;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);

  localparam logic [2:0] MODE_TICK       = 3'd0;
  localparam logic [2:0] MODE_REGISTER   = 3'd1;
  localparam logic [2:0] MODE_UNREGISTER = 3'd2;
  localparam logic [2:0] MODE_START      = 3'd3;
  localparam logic [2:0] MODE_STOP       = 3'd4;
  localparam logic [2:0] MODE_RESTART    = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] delay_us;
    logic        periodic;
    logic [15:0] handle;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] new_handle;
    logic        expired;
    logic [15:0] expired_handle;
    logic [2:0]  expired_slot;
  } out_t;

endpackage
`default_nettype wire

### src/stt_div.sv
`default_nettype none
module stt_div
  import stt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  busy,
  output logic [NUM_W-1:0]      quot
);

  logic [NUM_W-1:0]     q;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     den_r;
  logic [DIV_CNT_W-1:0] cnt;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_next;

  // Restoring division, one quotient bit per cycle. The dividend shifts out
  // of the top of q while quotient bits shift in at the bottom.
  always_comb begin
    trial    = {rem, q[NUM_W-1]};
    ge       = trial >= {1'b0, den_r};
    diff     = trial - {1'b0, den_r};
    rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      q     <= num;
      rem   <= '0;
      den_r <= den;
      cnt   <= DIV_CNT_W'(NUM_W);
      busy  <= 1'b1;
    end else if (busy) begin
      q   <= {q[NUM_W-2:0], ge};
      rem <= rem_next;
      cnt <= cnt - DIV_CNT_W'(1);
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quot = q;

endmodule
`default_nettype wire

### src/soft_timer_table_top.sv
// Every mode walks all slots in S_SCAN, then applies its result in S_APPLY; done and
// the result beat are registered from S_APPLY. Register with a free slot also waits in
// S_APPLY until the bit-serial reload divider is through. A new item is taken only in
// S_IDLE; busy covers the work.
// Reset (synchronous): all slots free and stopped, issue count zero, timebase 1000 us.
// The done beat lasts one cycle and cannot be held off by the receiver.
`default_nettype none
module soft_timer_table_top
  import stt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire in_t         item,
  input  wire logic        cfg_wr_en,
  input  wire logic [19:0] cfg_wr_data,
  output logic             done,
  output out_t             result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_t;

  state_t state;

  logic [19:0] timebase_us;
  logic [15:0] issue_count;

  in_t              req;
  logic [SLOT_W-1:0] walk;
  logic              hit;
  logic [SLOT_W-1:0] hit_idx;
  logic [15:0]       hit_handle;
  logic [14:0]       hit_rel;

  logic [15:0] slot_id        [SLOTS];
  logic [14:0] slot_remaining [SLOTS];
  logic [14:0] slot_reload    [SLOTS];
  logic        slot_repeats   [SLOTS];
  logic        slot_running   [SLOTS];

  // Divider hookup.
  logic             div_start;
  logic             div_busy;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [NUM_W-1:0] div_quot;
  logic [31:0]      delay_eff;
  logic [14:0]      reload_val;

  assign div_start = start && !busy && (item.mode == MODE_REGISTER);
  assign delay_eff = (item.delay_us < {12'd0, timebase_us}) ?
                     {12'd0, timebase_us} : item.delay_us;
  assign div_num   = {1'b0, delay_eff, 1'b0} + {14'd0, timebase_us};
  assign div_den   = {timebase_us, 1'b0};

  stt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  always_comb begin
    if (div_quot > {19'd0, MAX_RELOAD}) begin
      reload_val = MAX_RELOAD;
    end else if (div_quot == '0) begin
      reload_val = 15'd1;
    end else begin
      reload_val = div_quot[14:0];
    end
  end

  // Handle issue; the count skips the value whose handle would be zero.
  logic [15:0] cnt1;
  logic [15:0] cnt_new;
  logic [15:0] id_new;

  always_comb begin
    cnt1    = issue_count + 16'd1;
    cnt_new = ((HANDLE_BASE + cnt1) == 16'd0) ? cnt1 + 16'd1 : cnt1;
    id_new  = HANDLE_BASE + cnt_new;
  end

  // Entry under the walk pointer.
  logic [15:0] e_id;
  logic [14:0] e_rem;
  logic [14:0] e_rel;
  logic        e_rep;
  logic        e_run;
  logic        e_active;
  logic [14:0] e_dec;
  logic        e_fire;

  always_comb begin
    e_id     = slot_id[walk];
    e_rem    = slot_remaining[walk];
    e_rel    = slot_reload[walk];
    e_rep    = slot_repeats[walk];
    e_run    = slot_running[walk];
    e_active = (e_id != 16'd0) && e_run;
    e_dec    = (e_rem == 15'd0) ? 15'd0 : e_rem - 15'd1;
    e_fire   = e_active && !hit && (e_dec == 15'd0);
  end

  // Scan hit detection for the different modes.
  logic scan_hit;

  always_comb begin
    unique case (req.mode)
      MODE_TICK:     scan_hit = e_fire;
      MODE_REGISTER: scan_hit = !hit && (e_id == 16'd0);
      MODE_UNREGISTER, MODE_START, MODE_STOP, MODE_RESTART:
        scan_hit = !hit && (req.handle != 16'd0) && (e_id == req.handle);
      default:       scan_hit = 1'b0;
    endcase
  end

  logic apply_go;
  assign apply_go = !(req.mode == MODE_REGISTER && hit && div_busy);

  // Result beat assembled from the scan outcome.
  out_t result_next;

  always_comb begin
    result_next = '0;
    unique case (req.mode)
      MODE_TICK: begin
        result_next.expired = hit;
        if (hit) begin
          result_next.expired_handle = hit_handle;
          result_next.expired_slot   = 3'(hit_idx);
        end
      end
      MODE_REGISTER: begin
        if (hit) begin
          result_next.new_handle = id_new;
        end else begin
          result_next.status = ST_FULL;
        end
      end
      MODE_UNREGISTER, MODE_START, MODE_STOP, MODE_RESTART: begin
        result_next.status = hit ? ST_OK : ST_NOT_FOUND;
      end
      default: begin
      end
    endcase
  end

  // Slot table write port.
  logic              we_id, we_rem, we_rel, we_rep, we_run;
  logic [SLOT_W-1:0] wr_idx;
  logic [15:0]       wd_id;
  logic [14:0]       wd_rem;
  logic [14:0]       wd_rel;
  logic              wd_rep;
  logic              wd_run;

  always_comb begin
    we_id  = 1'b0;
    we_rem = 1'b0;
    we_rel = 1'b0;
    we_rep = 1'b0;
    we_run = 1'b0;
    wr_idx = hit_idx;
    wd_id  = 16'd0;
    wd_rem = 15'd0;
    wd_rel = 15'd0;
    wd_rep = 1'b0;
    wd_run = 1'b0;
    if (state == S_SCAN) begin
      wr_idx = walk;
      if (req.mode == MODE_TICK && e_active) begin
        we_rem = 1'b1;
        we_run = 1'b1;
        wd_rem = (e_fire && e_rep) ? e_rel : e_dec;
        wd_run = !(e_fire && !e_rep);
      end
    end else if (state == S_APPLY && hit && apply_go) begin
      case (req.mode)
        MODE_REGISTER: begin
          {we_id, we_rem, we_rel, we_rep, we_run} = 5'b11111;
          wd_id  = id_new;
          wd_rem = reload_val;
          wd_rel = reload_val;
          wd_rep = req.periodic;
        end
        MODE_UNREGISTER: begin
          {we_id, we_rem, we_rel, we_rep, we_run} = 5'b11111;
        end
        MODE_STOP: begin
          we_run = 1'b1;
        end
        MODE_START, MODE_RESTART: begin
          we_rem = 1'b1;
          we_run = 1'b1;
          wd_rem = hit_rel;
          wd_run = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_id[i]      <= 16'd0;
        slot_running[i] <= 1'b0;
      end
    end else begin
      if (we_id) begin
        slot_id[wr_idx] <= wd_id;
      end
      if (we_run) begin
        slot_running[wr_idx] <= wd_run;
      end
    end
  end

  // A free slot is never read before register writes all of its fields.
  always_ff @(posedge clk) begin
    if (we_rem) begin
      slot_remaining[wr_idx] <= wd_rem;
    end
    if (we_rel) begin
      slot_reload[wr_idx] <= wd_rel;
    end
    if (we_rep) begin
      slot_repeats[wr_idx] <= wd_rep;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timebase_us <= TIMEBASE_RESET;
    end else if (cfg_wr_en) begin
      timebase_us <= (cfg_wr_data < MIN_TIMEBASE) ? MIN_TIMEBASE : cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      hit         <= 1'b0;
      walk        <= '0;
      issue_count <= 16'd0;
      result      <= '0;
    end else begin
      done <= (state == S_APPLY) && apply_go;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req   <= item;
            hit   <= 1'b0;
            walk  <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            hit        <= 1'b1;
            hit_idx    <= walk;
            hit_handle <= e_id;
            hit_rel    <= e_rel;
          end
          if (walk == SLOT_W'(SLOTS - 1)) begin
            state <= S_APPLY;
          end else begin
            walk <= walk + SLOT_W'(1);
          end
        end
        S_APPLY: begin
          if (apply_go) begin
            result <= result_next;
            if (req.mode == MODE_REGISTER && hit) begin
              issue_count <= cnt_new;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

endmodule
`default_nettype wire
